@@ rtl/utf8_text_normalizer_defines.svh @@
// assertion macros for the rtl top level
`ifndef UTF8_TEXT_NORMALIZER_DEFINES_SVH
`define UTF8_TEXT_NORMALIZER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

@@ rtl/utn_pkg.sv @@
`default_nettype none

package utn_pkg;

   localparam int MAX_TEXT_DEFAULT = 65536;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [7:0] LEAD_4     = 8'hF0;
   localparam logic [7:0] LEAD_3     = 8'hE0;
   localparam logic [7:0] LEAD_2     = 8'hC0;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] TAB_CHAR   = 8'h09;
   localparam logic [7:0] LF_CHAR    = 8'h0A;
   localparam logic [7:0] CR_CHAR    = 8'h0D;

   // result of the replacement table lookup
   typedef struct packed {
      logic             hit;
      logic [1:0]       dlen;
      logic [2:0][7:0]  dst;   // dst[0] goes out first
   } utn_subst_type;

   // one entry of the queue: everything the back end needs to emit the beats
   typedef struct packed {
      logic             sp;        // held space goes out first
      logic [15:0]      sp_begin;
      logic [16:0]      sp_end;
      logic [2:0]       nb;        // character bytes after the space
      logic [3:0][7:0]  bytes;     // bytes[0] first
      logic [15:0]      ch_begin;
      logic [16:0]      ch_end;
      logic [2:0]       total;     // beats in this entry, 1 to 5
      logic             last;
      logic             ovf;
   } utn_rec_type;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      if (b >= LEAD_4) begin
         len = 3'd4;
      end else if (b >= LEAD_3) begin
         len = 3'd3;
      end else if (b >= LEAD_2) begin
         len = 3'd2;
      end else begin
         len = 3'd1;
      end
      return len;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == SPACE_CHAR) || (b == TAB_CHAR) || (b == LF_CHAR) || (b == CR_CHAR);
   endfunction

   // bytes are given first byte lowest, unused bytes zero
   function automatic utn_subst_type subst_lookup(input logic [2:0] len,
                                                  input logic [23:0] seq);
      utn_subst_type r;
      r.hit  = 1'b1;
      r.dlen = 2'd1;
      r.dst  = '0;
      unique case ({len, seq[7:0], seq[15:8], seq[23:16]})
         {3'd2, 8'hC2, 8'hB2, 8'h00}: begin
            r.dlen = 2'd2; r.dst[0] = 8'h5E; r.dst[1] = 8'h32;
         end
         {3'd2, 8'hC2, 8'hB3, 8'h00}: begin
            r.dlen = 2'd2; r.dst[0] = 8'h5E; r.dst[1] = 8'h33;
         end
         {3'd2, 8'hC2, 8'hB7, 8'h00}: r.dst[0] = 8'h2A;
         {3'd3, 8'hE2, 8'h8B, 8'h85}: r.dst[0] = 8'h2A;
         {3'd2, 8'hC3, 8'h97, 8'h00}: r.dst[0] = 8'h2A;
         {3'd3, 8'hE2, 8'h88, 8'h92}: r.dst[0] = 8'h2D;
         {3'd3, 8'hE2, 8'h80, 8'h93}: r.dst[0] = 8'h2D;
         {3'd2, 8'hC2, 8'hB1, 8'h00}: begin
            r.dlen = 2'd3; r.dst[0] = 8'h2B; r.dst[1] = 8'h2F; r.dst[2] = 8'h2D;
         end
         {3'd2, 8'hC2, 8'hB5, 8'h00}: r.dst[0] = 8'h75;
         {3'd2, 8'hCE, 8'hBC, 8'h00}: r.dst[0] = 8'h75;
         {3'd3, 8'hE2, 8'h80, 8'h99}: r.dst[0] = 8'h27;
         {3'd2, 8'hC2, 8'hA0, 8'h00}: r.dst[0] = SPACE_CHAR;
         default: begin
            r.hit  = 1'b0;
            r.dlen = 2'd0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/utn_front.sv @@
`default_nettype none

module utn_front #(
   parameter int MAX_TEXT = utn_pkg::MAX_TEXT_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         in_byte,
   input  wire logic               last_byte,
   output logic                    push,
   output utn_pkg::utn_rec_type    rec
);

   localparam int OFS_W = $clog2(MAX_TEXT + 1);
   localparam logic [OFS_W-1:0] MAX_OFS  = OFS_W'(MAX_TEXT);
   localparam logic [OFS_W-1:0] LAST_OFS = OFS_W'(MAX_TEXT - 1);

   logic [31:0]      char_buf_ff, char_buf_in;
   logic [1:0]       held_ff, held_in;
   logic [2:0]       char_len_ff, char_len_in;
   logic [OFS_W-1:0] char_start_ff, char_start_in;
   logic [OFS_W-1:0] byte_ofs_ff, byte_ofs_in;
   logic             sp_pend_ff, sp_pend_in;
   logic [OFS_W-1:0] sp_start_ff, sp_start_in;
   logic [OFS_W-1:0] sp_stop_ff, sp_stop_in;
   logic             emitted_ff, emitted_in;
   logic             ovf_ff, ovf_in;

   logic                   first;
   logic [2:0]             clen;
   logic [OFS_W-1:0]       cstart;
   logic [31:0]            cbuf;
   logic [31:0]            tail_word;
   logic [2:0]             cnt;
   logic [1:0]             tail_idx;
   logic [OFS_W-1:0]       ofs_next;
   logic                   ovf_next;
   logic                   done;
   utn_pkg::utn_subst_type sub;
   logic                   is_sp;
   logic                   trail;
   logic [2:0]             nb;
   logic [31:0]            seq;
   logic [OFS_W-1:0]       sp_beg_clamp, ch_beg_clamp;
   logic [31:0]            sp_beg_w, sp_end_w, ch_beg_w, ch_end_w;

   always_comb begin
      first    = (held_ff == 2'd0);
      clen     = first ? utn_pkg::lead_length(in_byte) : char_len_ff;
      cstart   = first ? byte_ofs_ff : char_start_ff;
      cbuf     = first ? 32'h0 : char_buf_ff;
      cbuf     = cbuf | (32'(in_byte) << {held_ff, 3'b000});
      cnt      = {1'b0, held_ff} + 3'd1;
      ofs_next = (byte_ofs_ff < MAX_OFS) ? byte_ofs_ff + 1'b1 : byte_ofs_ff;
      ovf_next = ovf_ff | (byte_ofs_ff >= MAX_OFS);
      done     = (cnt >= clen) || last_byte;

      sub       = utn_pkg::subst_lookup(cnt, cbuf[23:0]);
      tail_idx  = 2'(cnt - 3'd1);
      tail_word = cbuf >> {tail_idx, 3'b000};
      is_sp = sub.hit ? ((sub.dlen == 2'd1) && (sub.dst[0] == utn_pkg::SPACE_CHAR))
                      : ((cnt == 3'd1) && utn_pkg::is_blank(cbuf[7:0]));
      // a malformed or cut multibyte character ending in a space holds that space back
      trail = !sub.hit && (cnt >= 3'd2) && (tail_word[7:0] == utn_pkg::SPACE_CHAR);
      seq   = sub.hit ? {8'h00, sub.dst} : cbuf;
      nb    = sub.hit ? {1'b0, sub.dlen} : (cnt - {2'b00, trail});

      // offsets saturate, begin clamps one below the limit
      sp_beg_clamp = (sp_start_ff > LAST_OFS) ? LAST_OFS : sp_start_ff;
      ch_beg_clamp = (cstart > LAST_OFS) ? LAST_OFS : cstart;
      sp_beg_w     = 32'(sp_beg_clamp);
      sp_end_w     = 32'(sp_stop_ff);
      ch_beg_w     = 32'(ch_beg_clamp);
      ch_end_w     = 32'(ofs_next);
   end

   always_comb begin
      char_buf_in   = char_buf_ff;
      held_in       = held_ff;
      char_len_in   = char_len_ff;
      char_start_in = char_start_ff;
      byte_ofs_in   = byte_ofs_ff;
      sp_pend_in    = sp_pend_ff;
      sp_start_in   = sp_start_ff;
      sp_stop_in    = sp_stop_ff;
      emitted_in    = emitted_ff;
      ovf_in        = ovf_ff;

      rec          = '0;
      rec.sp_begin = sp_beg_w[15:0];
      rec.sp_end   = sp_end_w[16:0];
      rec.bytes    = seq;
      rec.ch_begin = ch_beg_w[15:0];
      rec.ch_end   = ch_end_w[16:0];
      rec.last     = last_byte;
      rec.ovf      = ovf_next;

      if (accept) begin
         byte_ofs_in = ofs_next;
         ovf_in      = ovf_next;
         if (!done) begin
            char_buf_in   = cbuf;
            held_in       = held_ff + 2'd1;
            char_len_in   = clen;
            char_start_in = cstart;
         end else begin
            char_buf_in = 32'h0;
            held_in     = 2'd0;
            char_len_in = cnt;
            if (is_sp) begin
               if (sp_pend_ff) begin
                  sp_stop_in = ofs_next;
               end else if (emitted_ff) begin
                  sp_pend_in  = 1'b1;
                  sp_start_in = cstart;
                  sp_stop_in  = ofs_next;
               end
            end else begin
               rec.sp     = sp_pend_ff;
               rec.nb     = nb;
               sp_pend_in = trail;
               emitted_in = 1'b1;
               if (trail) begin
                  sp_start_in = cstart;
                  sp_stop_in  = ofs_next;
               end
            end
         end
         if (last_byte) begin
            char_buf_in   = 32'h0;
            held_in       = 2'd0;
            char_len_in   = 3'd0;
            char_start_in = '0;
            byte_ofs_in   = '0;
            sp_pend_in    = 1'b0;
            sp_start_in   = '0;
            sp_stop_in    = '0;
            emitted_in    = 1'b0;
            ovf_in        = 1'b0;
         end
      end

      rec.total = {2'b00, rec.sp} + rec.nb;
      if (rec.total == 3'd0) begin
         rec.total = 3'd1;   // bare end-of-text marker
      end
      push = accept && done && (rec.sp || (rec.nb != 3'd0) || last_byte);
   end

   always_ff @(posedge clock) begin
      char_buf_ff   <= char_buf_in;
      char_len_ff   <= char_len_in;
      char_start_ff <= char_start_in;
      sp_start_ff   <= sp_start_in;
      sp_stop_ff    <= sp_stop_in;
      if (reset) begin
         held_ff     <= 2'd0;
         byte_ofs_ff <= '0;
         sp_pend_ff  <= 1'b0;
         emitted_ff  <= 1'b0;
         ovf_ff      <= 1'b0;
      end else begin
         held_ff     <= held_in;
         byte_ofs_ff <= byte_ofs_in;
         sp_pend_ff  <= sp_pend_in;
         emitted_ff  <= emitted_in;
         ovf_ff      <= ovf_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/utn_queue.sv @@
`default_nettype none

module utn_queue #(
   parameter int DEPTH = utn_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire utn_pkg::utn_rec_type  push_data,
   output logic                       full,
   input  wire logic                  pop,
   output utn_pkg::utn_rec_type       pop_data,
   output logic                       not_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   utn_pkg::utn_rec_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      not_empty = (count_ff != '0);
      pop_data  = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/utn_back.sv @@
`default_nettype none

module utn_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire utn_pkg::utn_rec_type  q_data,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_has_byte,
   output logic [15:0]                rsp_orig_begin,
   output logic [16:0]                rsp_orig_end,
   output logic                       rsp_run_end,
   output logic                       rsp_text_end,
   output logic                       rsp_overflow
);

   utn_pkg::utn_rec_type cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [2:0]           pos_ff, pos_in;

   logic       take;
   logic       beat_last;
   logic       space_beat;
   logic       marker;
   logic [2:0] idx;

   always_comb begin
      take       = cur_valid_ff && rsp_ready;
      beat_last  = (pos_ff == cur_ff.total - 3'd1);
      space_beat = cur_ff.sp && (pos_ff == 3'd0);
      marker     = !cur_ff.sp && (cur_ff.nb == 3'd0);
      idx        = pos_ff - {2'b00, cur_ff.sp};

      // next entry loads when none is held or as the last beat of the current one leaves
      pop          = q_valid && (!cur_valid_ff || (take && beat_last));
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      if (!cur_valid_ff || (take && beat_last)) begin
         cur_valid_in = q_valid;
         cur_in       = q_data;
         pos_in       = 3'd0;
      end else if (take) begin
         pos_in = pos_ff + 3'd1;
      end

      rsp_valid    = cur_valid_ff;
      rsp_has_byte = !marker;
      rsp_run_end  = beat_last;
      rsp_text_end = beat_last && cur_ff.last;
      rsp_overflow = cur_ff.ovf;
      if (marker) begin
         rsp_out_byte   = 8'h00;
         rsp_orig_begin = 16'h0;
         rsp_orig_end   = 17'h0;
      end else if (space_beat) begin
         rsp_out_byte   = utn_pkg::SPACE_CHAR;
         rsp_orig_begin = cur_ff.sp_begin;
         rsp_orig_end   = cur_ff.sp_end;
      end else begin
         rsp_out_byte   = cur_ff.bytes[idx[1:0]];
         rsp_orig_begin = cur_ff.ch_begin;
         rsp_orig_end   = cur_ff.ch_end;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pos_ff       <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/utf8_text_normalizer.sv @@
// order: a byte's result beats are registered in the queue, then in the output stage
// throughput: one input byte per cycle and one result beat per cycle while rsp_ready
//   is high; a byte that completes a character yields up to five beats, which the
//   output side drains while the front takes bytes until the four-entry queue fills
// reset: synchronous, active high; clears the character gatherer, offsets and queue
`default_nettype none
`include "utf8_text_normalizer_defines.svh"

module utf8_text_normalizer #(
   parameter int MAX_TEXT    = utn_pkg::MAX_TEXT_DEFAULT,
   parameter int QUEUE_DEPTH = utn_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic [15:0]      rsp_orig_begin,
   output logic [16:0]      rsp_orig_end,
   output logic             rsp_run_end,
   output logic             rsp_text_end,
   output logic             rsp_overflow
);

   utn_pkg::utn_rec_type push_rec;
   utn_pkg::utn_rec_type pop_rec;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_not_empty;
   logic                 accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   utn_front #(
      .MAX_TEXT (MAX_TEXT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .last_byte (req_last_byte),
      .push      (q_push),
      .rec       (push_rec)
   );

   utn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_rec),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_rec),
      .not_empty (q_not_empty)
   );

   utn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .q_data         (pop_rec),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_orig_begin (rsp_orig_begin),
      .rsp_orig_end   (rsp_orig_end),
      .rsp_run_end    (rsp_run_end),
      .rsp_text_end   (rsp_text_end),
      .rsp_overflow   (rsp_overflow)
   );

   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, q_push, !q_full)
   `ASSERT_NEXT(a_run_stays_valid, clock, reset, rsp_valid && rsp_ready && !rsp_run_end, rsp_valid)
   `ASSERT_IMPLIES(a_marker_ends_text, clock, reset, rsp_valid && !rsp_has_byte, rsp_text_end && rsp_run_end && rsp_out_byte == 8'h00)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned TEXT_LIMIT  = utn_pkg::MAX_TEXT_DEFAULT;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam int unsigned SETTLE      = 8;
   localparam int unsigned STUCK_LIMIT = 2000;
   localparam int unsigned RANDOM_BYTES = 110;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        has_byte;
      logic [15:0] orig_begin;
      logic [16:0] orig_end;
      logic        run_end;
      logic        text_end;
      logic        overflow;
   } beat_type;

   typedef enum int {
      PIECE_ASCII,
      PIECE_BLANK,
      PIECE_REPLACED,
      PIECE_UTF8,
      PIECE_BROKEN,
      PIECE_NOISE
   } piece_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_has_byte;
   logic [15:0] rsp_orig_begin;
   logic [16:0] rsp_orig_end;
   logic        rsp_run_end;
   logic        rsp_text_end;
   logic        rsp_overflow;

   // predictor state
   logic [31:0] gather_bytes;
   int unsigned gather_count;
   int unsigned gather_len;
   int unsigned gather_start;
   int unsigned text_offset;
   bit          space_held;
   int unsigned space_from;
   int unsigned space_to;
   bit          text_started;
   bit          offset_saturated;
   beat_type    step_beats [0:4];
   int unsigned step_count;

   beat_type    expected_beats [$];
   beat_type    checked_beat;
   int unsigned beats_checked = 0;
   int unsigned mismatch_count = 0;

   logic [7:0]  text_buf [$];
   bit          force_steady = 1'b0;
   int unsigned steady_left = 0;
   int unsigned hold_asks = 0;
   int unsigned hold_seen;
   int unsigned rsp_wait;
   int unsigned calm_left;
   int unsigned quiet_cycles = 0;

   utf8_text_normalizer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_orig_begin (rsp_orig_begin),
      .rsp_orig_end   (rsp_orig_end),
      .rsp_run_end    (rsp_run_end),
      .rsp_text_end   (rsp_text_end),
      .rsp_overflow   (rsp_overflow)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned seq_length(input logic [7:0] lead);
      int unsigned len;
      casez (lead)
         8'b1111????: len = 4;
         8'b1110????: len = 3;
         8'b11??????: len = 2;
         default:     len = 1;
      endcase
      return len;
   endfunction

   function automatic bit is_space_byte(input logic [7:0] b);
      return b == utn_pkg::SPACE_CHAR || b == utn_pkg::TAB_CHAR ||
             b == utn_pkg::LF_CHAR || b == utn_pkg::CR_CHAR;
   endfunction

   // first byte of the character sits in the low byte of chr
   function automatic string ascii_replacement(input int unsigned len,
                                               input logic [31:0] chr);
      string txt;
      txt = "";
      if (len == 2) begin
         case (chr[15:0])
            16'hB2C2:          txt = "^2";
            16'hB3C2:          txt = "^3";
            16'hB7C2, 16'h97C3: txt = "*";
            16'hB1C2:          txt = "+/-";
            16'hB5C2, 16'hBCCE: txt = "u";
            16'hA0C2:          txt = " ";
            default:           txt = "";
         endcase
      end else if (len == 3) begin
         case (chr[23:0])
            24'h858BE2:             txt = "*";
            24'h9288E2, 24'h9380E2: txt = "-";
            24'h9980E2:             txt = "'";
            default:                txt = "";
         endcase
      end
      return txt;
   endfunction

   task automatic clear_text_state();
      gather_bytes = '0;
      gather_count = 0;
      gather_len = 0;
      gather_start = 0;
      text_offset = 0;
      space_held = 1'b0;
      space_from = 0;
      space_to = 0;
      text_started = 1'b0;
      offset_saturated = 1'b0;
   endtask

   task automatic add_beat(input logic [7:0] value, input bit real_byte,
                           input int unsigned first_at, input int unsigned past_at);
      beat_type bt;
      if (first_at > TEXT_LIMIT - 1) first_at = TEXT_LIMIT - 1;
      if (past_at > TEXT_LIMIT) past_at = TEXT_LIMIT;
      bt.out_byte   = value;
      bt.has_byte   = real_byte;
      bt.orig_begin = first_at[15:0];
      bt.orig_end   = past_at[16:0];
      bt.run_end    = 1'b0;
      bt.text_end   = 1'b0;
      bt.overflow   = offset_saturated;
      step_beats[step_count] = bt;
      step_count++;
   endtask

   task automatic hold_space(input int unsigned first_at, input int unsigned past_at);
      if (space_held) begin
         space_to = past_at;
      end else if (text_started) begin
         space_held = 1'b1;
         space_from = first_at;
         space_to = past_at;
      end
   endtask

   task automatic finish_character();
      string       repl;
      int unsigned s;
      int unsigned e;
      logic [7:0]  b;
      s = gather_start;
      e = text_offset;
      repl = ascii_replacement(gather_len, gather_bytes);
      if (repl == " " || (repl == "" && gather_len == 1 && is_space_byte(gather_bytes[7:0])))
      begin
         hold_space(s, e);
         return;
      end
      if (space_held) begin
         add_beat(utn_pkg::SPACE_CHAR, 1'b1, space_from, space_to);
         space_held = 1'b0;
      end
      if (repl != "") begin
         for (int i = 0; i < repl.len(); i++) begin
            add_beat(repl[i], 1'b1, s, e);
            text_started = 1'b1;
         end
      end else begin
         for (int i = 0; i < gather_len; i++) begin
            b = gather_bytes[8*i +: 8];
            // a broken character that ends in a space byte keeps that byte as a held space
            if (i + 1 == gather_len && b == utn_pkg::SPACE_CHAR) begin
               space_held = 1'b1;
               space_from = s;
               space_to = e;
            end else begin
               add_beat(b, 1'b1, s, e);
               text_started = 1'b1;
            end
         end
      end
   endtask

   task automatic normalize_byte(input logic [7:0] b, input bit last);
      step_count = 0;
      if (gather_count == 0) begin
         gather_len = seq_length(b);
         gather_start = text_offset;
         gather_bytes = '0;
      end
      if (gather_count < 4) gather_bytes[8*gather_count +: 8] = b;
      gather_count++;
      if (text_offset < TEXT_LIMIT) text_offset++;
      else offset_saturated = 1'b1;
      if (gather_count >= gather_len || last) begin
         gather_len = gather_count;
         finish_character();
         gather_count = 0;
         gather_bytes = '0;
      end
      if (last) begin
         if (step_count == 0) add_beat(8'h00, 1'b0, 0, 0);
         step_beats[step_count-1].text_end = 1'b1;
      end
      if (step_count > 0) step_beats[step_count-1].run_end = 1'b1;
      for (int i = 0; i < step_count; i++) begin
         expected_beats.insert(expected_beats.size(), step_beats[i]);
      end
      if (last) clear_text_state();
   endtask

   // ---------------------------------------------------------------- drivers

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic append_text(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endtask

   task automatic send_byte(input logic [7:0] b, input bit last);
      int unsigned gap;
      if (force_steady) begin
         gap = 0;
      end else if (steady_left > 0) begin
         steady_left--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(31) == 0) steady_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      normalize_byte(b, last);
   endtask

   task automatic send_text_buf();
      for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // receiver: random stalls after beats, calm stretches, and a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
         hold_seen <= 0;
         calm_left <= 0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         rsp_ready <= 1'b0;
         rsp_wait  <= HOLD_CYCLES;
      end else if (rsp_wait != 0) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= rsp_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_valid && rsp_ready) begin
            if (calm_left != 0) begin
               calm_left <= calm_left - 1;
            end else begin
               rsp_wait <= pick_gap();
               if ($urandom_range(31) == 0) calm_left <= $urandom_range(15, 60);
            end
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at beat %0d: %s got 0x%0h want 0x%0h", beats_checked, what, got,
               want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat, out_byte", 32'(rsp_out_byte), 0);
         end else begin
            checked_beat = expected_beats.pop_front();
            if (rsp_out_byte !== checked_beat.out_byte)
               report_mismatch("out_byte", 32'(rsp_out_byte), 32'(checked_beat.out_byte));
            if (rsp_has_byte !== checked_beat.has_byte)
               report_mismatch("has_byte", 32'(rsp_has_byte), 32'(checked_beat.has_byte));
            if (rsp_orig_begin !== checked_beat.orig_begin)
               report_mismatch("orig_begin", 32'(rsp_orig_begin),
                               32'(checked_beat.orig_begin));
            if (rsp_orig_end !== checked_beat.orig_end)
               report_mismatch("orig_end", 32'(rsp_orig_end), 32'(checked_beat.orig_end));
            if (rsp_run_end !== checked_beat.run_end)
               report_mismatch("run_end", 32'(rsp_run_end), 32'(checked_beat.run_end));
            if (rsp_text_end !== checked_beat.text_end)
               report_mismatch("text_end", 32'(rsp_text_end), 32'(checked_beat.text_end));
            if (rsp_overflow !== checked_beat.overflow)
               report_mismatch("overflow", 32'(rsp_overflow), 32'(checked_beat.overflow));
         end
         beats_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STUCK_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic piece_kind_type pick_piece();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) return PIECE_ASCII;
      else if (r < 55) return PIECE_BLANK;
      else if (r < 72) return PIECE_REPLACED;
      else if (r < 84) return PIECE_UTF8;
      else if (r < 93) return PIECE_BROKEN;
      return PIECE_NOISE;
   endfunction

   // top byte is the length, then the bytes in order
   function automatic logic [31:0] replace_source(input int unsigned k);
      logic [31:0] src;
      case (k)
         0:       src = 32'h02C2B200;
         1:       src = 32'h02C2B300;
         2:       src = 32'h02C2B700;
         3:       src = 32'h03E28B85;
         4:       src = 32'h02C39700;
         5:       src = 32'h03E28892;
         6:       src = 32'h03E28093;
         7:       src = 32'h02C2B100;
         8:       src = 32'h02C2B500;
         9:       src = 32'h02CEBC00;
         10:      src = 32'h03E28099;
         default: src = 32'h02C2A000;
      endcase
      return src;
   endfunction

   task automatic add_piece();
      logic [31:0] src;
      int unsigned n;
      case (pick_piece())
         PIECE_ASCII: append_text(8'($urandom_range(8'h21, 8'h7E)));
         PIECE_BLANK: begin
            case ($urandom_range(3))
               0:       append_text(utn_pkg::SPACE_CHAR);
               1:       append_text(utn_pkg::TAB_CHAR);
               2:       append_text(utn_pkg::LF_CHAR);
               default: append_text(utn_pkg::CR_CHAR);
            endcase
         end
         PIECE_REPLACED: begin
            src = replace_source($urandom_range(11));
            n = 32'(src[31:24]);
            for (int i = 0; i < n; i++) append_text(src[23-8*i -: 8]);
         end
         PIECE_UTF8: begin
            n = $urandom_range(2, 4);
            case (n)
               2:       append_text(8'($urandom_range(8'hC2, 8'hDF)));
               3:       append_text(8'($urandom_range(8'hE0, 8'hEF)));
               default: append_text(8'($urandom_range(8'hF0, 8'hF4)));
            endcase
            for (int i = 1; i < n; i++) append_text(8'($urandom_range(8'h80, 8'hBF)));
         end
         PIECE_BROKEN: begin
            src[7:0] = 8'($urandom_range(8'hC0, 8'hFF));
            n = seq_length(src[7:0]);
            append_text(src[7:0]);
            for (int i = 1; i < n; i++) begin
               if (i == n - 1 && $urandom_range(1) == 1) append_text(utn_pkg::SPACE_CHAR);
               else append_text(8'($urandom_range(255)));
            end
         end
         default: append_text(8'($urandom_range(255)));
      endcase
   endtask

   task automatic test_space_runs();
      // leading space, a mixed run with a no-break space, trailing space
      text_buf = '{8'h20, 8'h61, 8'h09, 8'hC2, 8'hA0, 8'h0D, 8'h62, 8'h20};
      send_text_buf();
   endtask

   task automatic test_replacements();
      // plus-minus, minus sign, a character ending in a space byte, then a letter
      text_buf = '{8'hC2, 8'hB1, 8'hE2, 8'h88, 8'h92, 8'hC2, 8'h20, 8'h63};
      send_text_buf();
   endtask

   task automatic test_cut_short();
      text_buf = '{8'hFF, 8'h00};
      send_text_buf();
      text_buf = '{8'hE2, 8'h80};
      send_text_buf();
   endtask

   task automatic test_blank_text();
      // nothing comes out, so only the end-of-text marker
      text_buf = '{8'h20};
      send_text_buf();
   endtask

   task automatic test_output_stall();
      hold_asks <= hold_asks + 1;
      force_steady = 1'b1;
      text_buf = '{8'h61};
      repeat (8) begin
         append_text(8'hC2);
         append_text(8'hB1);
      end
      append_text(8'h7A);
      send_text_buf();
      force_steady = 1'b0;
   endtask

   task automatic test_random_texts();
      int unsigned sent;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         text_buf = {};
         repeat ($urandom_range(1, 10)) add_piece();
         // sometimes drop the last byte, which may cut the last character short at end of text
         if (text_buf.size() > 2 && $urandom_range(3) == 0) text_buf.delete(text_buf.size() - 1);
         send_text_buf();
         sent += text_buf.size();
      end
   endtask

   initial begin
      clear_text_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_space_runs();
      test_replacements();
      test_cut_short();
      test_blank_text();
      test_output_stall();
      test_random_texts();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
